// File: sv/one_touch_window_switch_defines.svh
// ----------------------------------------------------------------------------
// one_touch_window_switch_defines
// Assertion macros shared by the window switch RTL.
// ----------------------------------------------------------------------------
`ifndef ONE_TOUCH_WINDOW_SWITCH_DEFINES_SVH
`define ONE_TOUCH_WINDOW_SWITCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OTWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/otws_pkg.sv
// ----------------------------------------------------------------------------
// otws_pkg
// Types and constants of the one-touch window switch.
// ----------------------------------------------------------------------------
package otws_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam logic [31:0] THRESHOLD_RESET = 32'd500000;

  // button codes
  localparam logic [2:0] CMD_GLASS_UP   = 3'd0;
  localparam logic [2:0] CMD_GLASS_DOWN = 3'd1;
  localparam logic [2:0] CMD_SHADE_UP   = 3'd2;
  localparam logic [2:0] CMD_SHADE_DOWN = 3'd3;
  localparam logic [2:0] CMD_CLEAN      = 3'd4;
  localparam logic [2:0] CMD_BRIGHT     = 3'd5;
  localparam logic [2:0] CMD_DRIVE      = 3'd6;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  // roof modes
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_CLEAN  = 2'd1;
  localparam logic [1:0] MODE_BRIGHT = 2'd2;

  typedef struct packed {
    logic [31:0] time_us;
    logic        level;
    logic [2:0]  command;
  } otws_item_t;

  typedef struct packed {
    logic       drive_active;
    logic [1:0] roof_mode;
    logic       shade_down_on;
    logic       shade_up_on;
    logic       glass_down_on;
    logic       glass_up_on;
  } otws_result_t;

endpackage

// File: sv/otws_in_reg.sv
// ----------------------------------------------------------------------------
// otws_in_reg
// Input register: holds one accepted event until the decoder takes it.
// ----------------------------------------------------------------------------
module otws_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  otws_pkg::otws_item_t in_item,
  input  logic                 take,      // decoder consumes held item
  output logic                 item_valid,
  output otws_pkg::otws_item_t item
);
  import otws_pkg::*;

  logic       valid_r;
  otws_item_t item_r;

  // free slot, or slot empties this cycle
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: sv/otws_ctrl.sv
// ----------------------------------------------------------------------------
// otws_ctrl
// Button state, press timing, motion flags, mode and drive; one event per cycle while fire is high.
// ----------------------------------------------------------------------------
module otws_ctrl #(
  parameter int TIME_BITS = otws_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_data,
  input  logic                   fire,     // process item this cycle
  input  otws_pkg::otws_item_t   item,
  output otws_pkg::otws_result_t result
);
  import otws_pkg::*;

  localparam int CMP_W = 64;

  logic [6:0]           last_r, last_nxt;
  logic [TIME_BITS-1:0] press_r [4];
  logic [3:0]           flags_r, flags_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 drive_r, drive_nxt;
  logic [31:0]          thr_r;

  logic [7:0]           lv_ext;
  logic                 prev, rise, fall, known, motion;
  logic [1:0]           idx;
  logic [3:0]           own, other;
  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now, held;
  logic [CMP_W-1:0]     held_ext, thr_ext;
  logic                 long_press;

  assign lv_ext = {1'b0, last_r};
  assign prev   = lv_ext[item.command];
  assign rise   = item.level && !prev;
  assign fall   = !item.level && prev;
  assign known  = (item.command != CMD_UNUSED);
  assign motion = (item.command <= CMD_SHADE_DOWN);
  assign idx    = item.command[1:0];
  assign own    = 4'b0001 << idx;
  assign other  = 4'b0001 << (idx ^ 2'b01);

  // wrapping press length at TIME_BITS
  assign now_ext    = {32'd0, item.time_us};
  assign now        = now_ext[TIME_BITS-1:0];
  assign held       = now - press_r[idx];
  assign held_ext   = CMP_W'(held);
  assign thr_ext    = CMP_W'(thr_r);
  assign long_press = held_ext > thr_ext;

  always_comb begin
    last_nxt  = last_r;
    flags_nxt = flags_r;
    mode_nxt  = mode_r;
    drive_nxt = drive_r;
    if (known) begin
      last_nxt[item.command] = item.level;
    end
    case (item.command)
      CMD_GLASS_UP, CMD_GLASS_DOWN, CMD_SHADE_UP, CMD_SHADE_DOWN: begin
        mode_nxt = MODE_MANUAL;
        if (rise || (fall && !long_press)) begin
          flags_nxt = (flags_r | own) & ~other;   // start, or one-touch latch
        end else if (fall) begin
          flags_nxt = flags_r & ~own;
        end
      end
      CMD_CLEAN: begin
        if (rise) mode_nxt = MODE_CLEAN;
      end
      CMD_BRIGHT: begin
        if (rise) mode_nxt = MODE_BRIGHT;
      end
      CMD_DRIVE: begin
        if (rise) drive_nxt = 1'b1;
        if (fall) drive_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      flags_r <= '0;
      mode_r  <= MODE_MANUAL;
      drive_r <= 1'b0;
      thr_r   <= THRESHOLD_RESET;
      for (int i = 0; i < 4; i++) begin
        press_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (fire) begin
        last_r  <= last_nxt;
        flags_r <= flags_nxt;
        mode_r  <= mode_nxt;
        drive_r <= drive_nxt;
        if (motion && rise) begin
          press_r[idx] <= now;
        end
      end
    end
  end

  assign result.glass_up_on   = flags_nxt[0];
  assign result.glass_down_on = flags_nxt[1];
  assign result.shade_up_on   = flags_nxt[2];
  assign result.shade_down_on = flags_nxt[3];
  assign result.roof_mode     = mode_nxt;
  assign result.drive_active  = drive_nxt;

endmodule

// File: sv/otws_out_reg.sv
// ----------------------------------------------------------------------------
// otws_out_reg
// Result register; frees itself whenever the downstream side takes it.
// ----------------------------------------------------------------------------
module otws_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  otws_pkg::otws_result_t result,
  output logic                   space,     // may load this cycle
  output logic                   out_valid,
  input  logic                   out_ready,
  output otws_pkg::otws_result_t out_result
);
  import otws_pkg::*;

  logic         valid_r;
  otws_result_t res_r;

  assign space      = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

// File: sv/one_touch_window_switch.sv
// ----------------------------------------------------------------------------
// one_touch_window_switch
// Button-event decoder for a glass panel and a shade, with one-touch latch.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                        | content
//  --------+-----+------------------------------+------------------------------
//  in      | in  | in_tvalid/tready/tdata/tuser | one button change event
//  out     | out | out_tvalid/tready/tdata      | motion, mode and drive flags
//  cfg     | in  | cfg_valid/ready/data         | hold threshold in us
//
//  One result per event. Throughput one transfer per cycle while out_tready
//  keeps up; an accepted event is held in the input register, then decoded
//  into the result register, which drives out_tvalid. Button state updates
//  as the result register loads, so a following event sees it right away.
//  rst_n is synchronous: levels, press times, flags, mode and drive clear,
//  threshold returns to 500000 us.
//  A stalled result register stalls the decoder; the input register still
//  takes one more event if empty, then in_tready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "one_touch_window_switch_defines.svh"

module one_touch_window_switch #(
  parameter int TIME_BITS = otws_pkg::TIME_BITS_DEF   // press time width, 16..64
) (
  input  logic        clk,
  input  logic        rst_n,
  // event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] level, [32:1] time_us, [39:33] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] glass_up_on, [1] glass_down_on,
                                  // [2] shade_up_on, [3] shade_down_on,
                                  // [5:4] roof_mode, [6] drive_active, [7] zero
  // threshold write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import otws_pkg::*;

  otws_item_t   in_item, item;
  otws_result_t result, out_result;
  logic         item_valid, space, fire;

  assign in_item.command = in_tuser;
  assign in_item.level   = in_tdata[0];
  assign in_item.time_us = in_tdata[32:1];

  assign cfg_ready = 1'b1;

  // decode happens when an event is held and the result slot is free
  assign fire = item_valid && space;

  otws_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  otws_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .fire     (fire),
    .item     (item),
    .result   (result)
  );

  otws_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .space      (space),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {1'b0, out_result.drive_active, out_result.roof_mode,
                      out_result.shade_down_on, out_result.shade_up_on,
                      out_result.glass_down_on, out_result.glass_up_on};

  // opposite directions of one panel are never requested together
  `OTWS_ASSERT_NOW(a_glass_excl, out_tvalid, !(out_tdata[0] && out_tdata[1]), "glass both ways")
  `OTWS_ASSERT_NOW(a_shade_excl, out_tvalid, !(out_tdata[2] && out_tdata[3]), "shade both ways")
  // mode code three is never produced
  `OTWS_ASSERT_NOW(a_mode_code, out_tvalid, out_tdata[5:4] != 2'b11, "roof mode out of range")
  // a held event that cannot move on stays held
  `OTWS_ASSERT_NEXT(a_item_held, item_valid && !fire, item_valid, "held event dropped")

endmodule
